// ===== rtl/cpa_pkg.sv =====
package cpa_pkg;

  typedef enum logic [3:0] {
    OP_NOP  = 4'd0,
    OP_ADD  = 4'd1,
    OP_SUB  = 4'd2,
    OP_MULT = 4'd3,
    OP_SL   = 4'd4,
    OP_SR   = 4'd5,
    OP_SRA  = 4'd6,
    OP_SEL  = 4'd7,
    OP_CAT  = 4'd8,
    OP_NOT  = 4'd9,
    OP_AND  = 4'd10,
    OP_OR   = 4'd11,
    OP_XOR  = 4'd12,
    OP_EQL  = 4'd13,
    OP_GT   = 4'd14,
    OP_LT   = 4'd15
  } op_e;

  localparam int unsigned OpBits = 4;

endpackage

// ===== rtl/cpa_if.sv =====
interface cpa_req_if #(
  parameter int unsigned WORD_BITS = 24
);
  logic                 valid;
  logic                 ready;
  logic [3:0]           operation;
  logic [WORD_BITS:0]   operand_a;
  logic [WORD_BITS:0]   operand_b;

  modport source (output valid, output operation, output operand_a, output operand_b,
                  input ready);
  modport sink   (input valid, input operation, input operand_a, input operand_b,
                  output ready);
endinterface

interface cpa_rsp_if #(
  parameter int unsigned WORD_BITS = 24
);
  logic                 valid;
  logic                 ready;
  logic [WORD_BITS:0]   result;

  modport source (output valid, output result, input ready);
  modport sink   (input valid, input result, output ready);
endinterface

// ===== rtl/carry_tagged_pe_alu.sv =====
// ALU of one array processing element. Each word is a WORD_BITS magnitude with
// a carry/sign flag in bit WORD_BITS. An operation transfer is captured in an
// input register and its result moves into an output register once that
// register is empty or being taken, and then shows on out_o. One operation is
// accepted every cycle while out_o is not stalled; the path from ready of out_o
// to ready of in_i is combinational, and the input register takes one more
// operation while a finished result waits at the output, after which in_i
// stalls until out_o is taken. The longest logic is the WORD_BITS x WORD_BITS
// magnitude multiplier between the two registers.
module carry_tagged_pe_alu
  import cpa_pkg::*;
#(
  parameter int unsigned WORD_BITS = 24
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  cpa_req_if.sink    in_i,
  cpa_rsp_if.source  out_o
);

  localparam int unsigned DataBits = WORD_BITS + 1;
  localparam int unsigned ShBits   = $clog2(WORD_BITS + 1);

  logic                s1_valid_q;
  op_e                 op_q;
  logic [WORD_BITS:0]  a_q;
  logic [WORD_BITS:0]  b_q;
  logic                s2_valid_q;
  logic [WORD_BITS:0]  res_q;
  logic [WORD_BITS:0]  res_d;
  logic                s1_adv;
  logic                in_xfer;

  logic [WORD_BITS-1:0]   mag_a;
  logic [WORD_BITS-1:0]   mag_b;
  logic [2*WORD_BITS-1:0] prod;
  logic                   sh_big;
  logic [ShBits-1:0]      sh_amt;
  logic                   a_gt_b;

  assign s1_adv      = !s2_valid_q || out_o.ready;
  assign in_i.ready  = !s1_valid_q || s1_adv;
  assign in_xfer     = in_i.valid && in_i.ready;
  assign out_o.valid = s2_valid_q;
  assign out_o.result = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (s1_adv) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q <= op_e'(in_i.operation[OpBits-1:0]);
      a_q  <= in_i.operand_a;
      b_q  <= in_i.operand_b;
    end
    if (s1_adv && s1_valid_q) begin
      res_q <= res_d;
    end
  end

  assign mag_a  = a_q[WORD_BITS-1:0];
  assign mag_b  = b_q[WORD_BITS-1:0];
  assign prod   = mag_a * mag_b;
  assign sh_big = b_q > DataBits'(WORD_BITS);
  assign sh_amt = b_q[ShBits-1:0];

  always_comb begin
    case ({a_q[WORD_BITS], b_q[WORD_BITS]})
      2'b00:   a_gt_b = mag_a > mag_b;
      2'b01:   a_gt_b = 1'b1;
      2'b11:   a_gt_b = mag_a < mag_b;
      default: a_gt_b = 1'b0;
    endcase
  end

  always_comb begin
    case (op_q)
      OP_NOP:  res_d = '0;
      OP_ADD:  res_d = a_q + b_q;
      OP_SUB:  res_d = a_q - b_q;
      OP_MULT: res_d = {a_q[WORD_BITS] ^ b_q[WORD_BITS], prod[WORD_BITS-1:0]};
      OP_SL:   res_d = sh_big ? '0 : (a_q << sh_amt);
      OP_SR:   res_d = sh_big ? '0 : (a_q >> sh_amt);
      OP_SRA:  res_d = sh_big ? '0 : DataBits'($signed(a_q) >>> sh_amt);
      OP_SEL:  res_d = a_q[WORD_BITS] ? b_q : a_q;
      OP_CAT:  res_d = a_q;
      OP_NOT:  res_d = ~a_q;
      OP_AND:  res_d = a_q & b_q;
      OP_OR:   res_d = a_q | b_q;
      OP_XOR:  res_d = a_q ^ b_q;
      OP_EQL:  res_d = (mag_a == mag_b) ? {1'b1, mag_a} : '0;
      OP_GT:   res_d = {a_gt_b, {WORD_BITS{1'b0}}};
      OP_LT:   res_d = {!a_gt_b, {WORD_BITS{1'b0}}};
      default: res_d = '0;
    endcase
  end

endmodule

// ===== rtl/cpa_check.sv =====
module cpa_check #(
  parameter int unsigned WORD_BITS = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [WORD_BITS:0] out_result_i
);

  logic in_xfer;

  assign in_xfer = in_valid_i && in_ready_i;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_result_i))
    else $error("stalled result changed or dropped");

  // a free output side never blocks input
  a_ready_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_i)
    else $error("input stalled while output is free");

  // every transfer reaches the output through the input and output registers
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> ##1 out_valid_i)
    else $error("result missing after input transfer");

  // drain: no invented results
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!in_xfer && out_ready_i) ##1 (!in_xfer && out_ready_i) |=> !out_valid_i)
    else $error("result without input transfer");

endmodule

bind carry_tagged_pe_alu cpa_check #(
  .WORD_BITS (WORD_BITS)
) u_cpa_check (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_result_i (out_o.result)
);
